/* rtl/bpe_pkg.sv */
`default_nettype none

package bpe_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DEG_W           = 8;
  localparam int NUM_PTS         = 4;
  localparam int NUM_STG         = 9;

  localparam logic [1:0] MAX_DEGREE = 2'd3;

  // C(n,k), zero where k exceeds n
  localparam logic [1:0] BINOM [0:3][0:3] = '{
    '{2'd1, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd3, 2'd3, 2'd1}
  };

endpackage

`default_nettype wire

/* rtl/bezier_point_evaluator.sv */
`default_nettype none

// Bezier curve point evaluator for degree 0 to 3. Each transfer carries four
// signed Q12.4 control points, a degree (above 3 acts as 3) and t in
// Q1.T_FRAC_BITS (values above 1.0 act as 1.0); one point comes back per item,
// rounded and saturated to the coordinate range. The datapath is a nine stage
// pipeline: clamp, squares, cubes, weight products, binomial scaling, point
// products, sum, magnitude rounding, saturation. It takes one item every cycle
// while in_stall is low. Every stage holds its own valid bit, so a stall at the
// output fills empty stages before the input is stalled.
module bezier_point_evaluator #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [bpe_pkg::DEG_W-1:0]     in_degree,
  input  wire  [T_FRAC_BITS:0]          in_t_param,
  input  wire  signed [COORD_WIDTH-1:0] in_p0_x,
  input  wire  signed [COORD_WIDTH-1:0] in_p0_y,
  input  wire  signed [COORD_WIDTH-1:0] in_p1_x,
  input  wire  signed [COORD_WIDTH-1:0] in_p1_y,
  input  wire  signed [COORD_WIDTH-1:0] in_p2_x,
  input  wire  signed [COORD_WIDTH-1:0] in_p2_y,
  input  wire  signed [COORD_WIDTH-1:0] in_p3_x,
  input  wire  signed [COORD_WIDTH-1:0] in_p3_y,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [COORD_WIDTH-1:0] out_curve_x,
  output logic signed [COORD_WIDTH-1:0] out_curve_y
);

  localparam int CW     = COORD_WIDTH;
  localparam int F      = T_FRAC_BITS;
  localparam int NS     = bpe_pkg::NUM_STG;
  localparam int NP     = bpe_pkg::NUM_PTS;
  localparam int ONE_W  = F + 1;
  localparam int PP_W   = 2 * ONE_W;
  localparam int SQ_W   = 2 * F + 1;
  localparam int W_W    = F + 2;
  localparam int PR_W   = W_W + 1 + CW;
  localparam int ACC_W  = PR_W + 2;
  localparam int RM_W   = ACC_W - F;
  localparam int HALF   = 1 << (F - 1);

  localparam logic [ONE_W-1:0] ONE     = {1'b1, {F{1'b0}}};
  localparam logic [RM_W-1:0]  MAX_MAG = RM_W'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [RM_W-1:0]  MIN_MAG = RM_W'(64'd1 << (CW - 1));

  // valid and ready per stage
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // control points travel alongside until the point products
  logic signed [CW-1:0] pin [0:2*NP-1];
  logic signed [CW-1:0] pt_r [0:4][0:2*NP-1];
  logic [1:0]           n_r [0:3];

  assign pin[0] = in_p0_x;
  assign pin[1] = in_p0_y;
  assign pin[2] = in_p1_x;
  assign pin[3] = in_p1_y;
  assign pin[4] = in_p2_x;
  assign pin[5] = in_p2_y;
  assign pin[6] = in_p3_x;
  assign pin[7] = in_p3_y;

  // stage 1: clamp t and degree
  logic [ONE_W-1:0] s1_t_nxt, s1_u_nxt, s1_t_r, s1_u_r;
  logic [1:0]       s1_n_nxt;

  always_comb begin
    s1_t_nxt = (in_t_param > ONE) ? ONE : in_t_param;
    s1_u_nxt = ONE - s1_t_nxt;
    s1_n_nxt = (in_degree > bpe_pkg::DEG_W'(bpe_pkg::MAX_DEGREE)) ?
               bpe_pkg::MAX_DEGREE : in_degree[1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_t_r  <= s1_t_nxt;
      s1_u_r  <= s1_u_nxt;
      n_r[0]  <= s1_n_nxt;
      pt_r[0] <= pin;
    end
    for (int s = 1; s < 5; s++) begin
      if (rdy[s]) pt_r[s] <= pt_r[s-1];
    end
    for (int s = 1; s < 4; s++) begin
      if (rdy[s]) n_r[s] <= n_r[s-1];
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0]  s2_tt_nxt, s2_uu_nxt, s2_tt_r, s2_uu_r;
  logic [ONE_W-1:0] s2_t_r, s2_u_r;

  always_comb begin
    s2_tt_nxt = SQ_W'(PP_W'(s1_t_r) * PP_W'(s1_t_r));
    s2_uu_nxt = SQ_W'(PP_W'(s1_u_r) * PP_W'(s1_u_r));
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_tt_r <= s2_tt_nxt;
      s2_uu_r <= s2_uu_nxt;
      s2_t_r  <= s1_t_r;
      s2_u_r  <= s1_u_r;
    end
  end

  // stage 3: round squares, form cubes
  logic [SQ_W-1:0]  s3_tt_rnd, s3_uu_rnd;
  logic [ONE_W-1:0] s3_t2_nxt, s3_u2_nxt, s3_t2_r, s3_u2_r, s3_t_r, s3_u_r;
  logic [SQ_W-1:0]  s3_t3p_nxt, s3_u3p_nxt, s3_t3p_r, s3_u3p_r;

  always_comb begin
    s3_tt_rnd  = s2_tt_r + SQ_W'(HALF);
    s3_uu_rnd  = s2_uu_r + SQ_W'(HALF);
    s3_t2_nxt  = s3_tt_rnd[SQ_W-1:F];
    s3_u2_nxt  = s3_uu_rnd[SQ_W-1:F];
    s3_t3p_nxt = SQ_W'(PP_W'(s3_t2_nxt) * PP_W'(s2_t_r));
    s3_u3p_nxt = SQ_W'(PP_W'(s3_u2_nxt) * PP_W'(s2_u_r));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_t_r   <= s2_t_r;
      s3_u_r   <= s2_u_r;
      s3_t2_r  <= s3_t2_nxt;
      s3_u2_r  <= s3_u2_nxt;
      s3_t3p_r <= s3_t3p_nxt;
      s3_u3p_r <= s3_u3p_nxt;
    end
  end

  // stage 4: t^k * u^(n-k) for each k
  logic [SQ_W-1:0]  s4_t3_rnd, s4_u3_rnd;
  logic [ONE_W-1:0] tp [0:3];
  logic [ONE_W-1:0] up [0:3];
  logic [1:0]       s4_idx [0:3];
  logic [SQ_W-1:0]  s4_m_nxt [0:3];
  logic [SQ_W-1:0]  s4_m_r [0:3];

  always_comb begin
    s4_t3_rnd = s3_t3p_r + SQ_W'(HALF);
    s4_u3_rnd = s3_u3p_r + SQ_W'(HALF);
    tp[0] = ONE;
    tp[1] = s3_t_r;
    tp[2] = s3_t2_r;
    tp[3] = s4_t3_rnd[SQ_W-1:F];
    up[0] = ONE;
    up[1] = s3_u_r;
    up[2] = s3_u2_r;
    up[3] = s4_u3_rnd[SQ_W-1:F];
    for (int k = 0; k < NP; k++) begin
      // index wraps where k exceeds n; the binomial zeroes that term later
      s4_idx[k]   = n_r[2] - 2'(k);
      s4_m_nxt[k] = SQ_W'(PP_W'(tp[k]) * PP_W'(up[s4_idx[k]]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) s4_m_r <= s4_m_nxt;
  end

  // stage 5: weights
  logic [SQ_W-1:0] s5_rnd [0:3];
  logic [W_W-1:0]  s5_w_nxt [0:3];
  logic [W_W-1:0]  s5_w_r [0:3];

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      s5_rnd[k]   = s4_m_r[k] + SQ_W'(HALF);
      s5_w_nxt[k] = W_W'(s5_rnd[k][SQ_W-1:F]) *
                    W_W'(bpe_pkg::BINOM[n_r[3]][2'(k)]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) s5_w_r <= s5_w_nxt;
  end

  // stage 6: weight times point
  logic signed [W_W:0]    s6_ws [0:3];
  logic signed [PR_W-1:0] s6_px_nxt [0:3];
  logic signed [PR_W-1:0] s6_py_nxt [0:3];
  logic signed [PR_W-1:0] s6_px_r [0:3];
  logic signed [PR_W-1:0] s6_py_r [0:3];

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      s6_ws[k]     = signed'({1'b0, s5_w_r[k]});
      s6_px_nxt[k] = PR_W'(s6_ws[k]) * PR_W'(pt_r[4][2*k]);
      s6_py_nxt[k] = PR_W'(s6_ws[k]) * PR_W'(pt_r[4][2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_px_r <= s6_px_nxt;
      s6_py_r <= s6_py_nxt;
    end
  end

  // stage 7: accumulate
  logic signed [ACC_W-1:0] s7_ax_nxt, s7_ay_nxt, s7_ax_r, s7_ay_r;

  always_comb begin
    s7_ax_nxt = ACC_W'(s6_px_r[0]) + ACC_W'(s6_px_r[1]) +
                ACC_W'(s6_px_r[2]) + ACC_W'(s6_px_r[3]);
    s7_ay_nxt = ACC_W'(s6_py_r[0]) + ACC_W'(s6_py_r[1]) +
                ACC_W'(s6_py_r[2]) + ACC_W'(s6_py_r[3]);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_ax_r <= s7_ax_nxt;
      s7_ay_r <= s7_ay_nxt;
    end
  end

  // stage 8: round magnitude, ties away from zero
  logic [ACC_W-1:0] s8_magx, s8_magy, s8_sumx, s8_sumy;
  logic [RM_W-1:0]  s8_mx_r, s8_my_r;
  logic             s8_nx_r, s8_ny_r;

  always_comb begin
    s8_magx = s7_ax_r[ACC_W-1] ? ACC_W'(-s7_ax_r) : ACC_W'(s7_ax_r);
    s8_magy = s7_ay_r[ACC_W-1] ? ACC_W'(-s7_ay_r) : ACC_W'(s7_ay_r);
    s8_sumx = s8_magx + ACC_W'(HALF);
    s8_sumy = s8_magy + ACC_W'(HALF);
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_mx_r <= s8_sumx[ACC_W-1:F];
      s8_my_r <= s8_sumy[ACC_W-1:F];
      s8_nx_r <= s7_ax_r[ACC_W-1];
      s8_ny_r <= s7_ay_r[ACC_W-1];
    end
  end

  // stage 9: restore sign and saturate
  logic signed [CW-1:0] s9_x_nxt, s9_y_nxt, s9_x_r, s9_y_r;

  always_comb begin
    if (s8_nx_r) begin
      s9_x_nxt = (s8_mx_r > MIN_MAG) ? CW'(MIN_MAG) : CW'(-s8_mx_r);
    end else begin
      s9_x_nxt = (s8_mx_r > MAX_MAG) ? CW'(MAX_MAG) : CW'(s8_mx_r);
    end
    if (s8_ny_r) begin
      s9_y_nxt = (s8_my_r > MIN_MAG) ? CW'(MIN_MAG) : CW'(-s8_my_r);
    end else begin
      s9_y_nxt = (s8_my_r > MAX_MAG) ? CW'(MAX_MAG) : CW'(s8_my_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s9_x_r <= s9_x_nxt;
      s9_y_r <= s9_y_nxt;
    end
  end

  assign out_curve_x = s9_x_r;
  assign out_curve_y = s9_y_r;

endmodule

`default_nettype wire

/* rtl/bpe_checker.sv */
`default_nettype none

module bpe_checker #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire [COORD_WIDTH-1:0] out_curve_x,
  input wire [COORD_WIDTH-1:0] out_curve_y
);

  // items taken in and not yet handed out
  logic [4:0] flight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else begin
      flight_r <= flight_r + 5'(in_valid && !in_stall) - 5'(out_valid && !out_stall);
    end
  end

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // the input only waits when a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // a result needs a transfer behind it, and the pipeline holds at most one item per stage
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (flight_r <= 5'(bpe_pkg::NUM_STG)) && (!out_valid || flight_r != '0))
    else $error("result without a matching transfer or pipeline overfilled");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_curve_x) && $stable(out_curve_y)))
    else $error("stalled result changed or dropped");

endmodule

bind bezier_point_evaluator bpe_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_curve_x (out_curve_x),
  .out_curve_y (out_curve_y)
);

`default_nettype wire
